### hw/rtl/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

    localparam int PAGES         = 1024;
    localparam int TOP_ORDER     = 10;
    localparam int RESERVE_SLOTS = 8;

    localparam int ADDR_W  = $clog2(PAGES);
    localparam int LINK_W  = ADDR_W + 1;
    localparam int MARK_W  = ADDR_W + 2;
    localparam int ORD_W   = 4;
    localparam int TAG_W   = 5;
    localparam int LISTS   = TOP_ORDER + 1;
    localparam int SLOT_IW = (RESERVE_SLOTS > 1) ? $clog2(RESERVE_SLOTS) : 1;
    localparam int USED_W  = $clog2(RESERVE_SLOTS + 1);
    localparam int PC_W    = 11;
    localparam int PAGE_NW = 36;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(PAGES);

    localparam logic [TAG_W-1:0] TAG_TAIL     = 5'd31;
    localparam logic [TAG_W-1:0] TAG_RESERVED = 5'd30;

    localparam logic [1:0] OP_RESERVE  = 2'd0;
    localparam logic [1:0] OP_BUILD    = 2'd1;
    localparam logic [1:0] OP_ALLOCATE = 2'd2;
    localparam logic [1:0] OP_FREE     = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic CFG_PAGE_COUNT = 1'b0;
    localparam logic CFG_BASE_PAGE  = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  block_order;
        logic [9:0]  page_index;
        logic [35:0] range_start;
        logic [35:0] range_pages;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] result_page;
        logic [3:0] result_order;
    } result_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             used;
    } page_ent_t;

    typedef struct packed {
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
    } link_ent_t;

    function automatic logic [MARK_W-1:0] ord_size(input logic [ORD_W-1:0] ord);
        ord_size = MARK_W'(1) << ord;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/buddy_page_allocator_top.sv
// Channel  | Ports                          | Handshake
// command  | start, busy, cmd               | taken when start & !busy
// result   | done, result                   | one-cycle strobe, no backpressure
// config   | cfg_we, cfg_index, cfg_data    | written when cfg_we is high
//
// One item at a time through a sequencer over the page and link memories.
// Reserve: result in the cycle after accept; rejected allocate/free: decided in
// S_AL0, S_FR0 or S_FR1. Allocate/free: length set by the page-tag marking walk
// (one page per cycle) and list relinks (S_AP1-S_AP2 append, S_UN1-S_UN3 unlink).
// Build: a sweep over every page plus per-block overlap checks (one slot a cycle).
// After reset busy stays high through a clearing pass; no result stalls.
`timescale 1ns / 1ps
`default_nettype none

module buddy_page_allocator_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire bpa_pkg::cmd_t        cmd,
    output logic                      done,
    output bpa_pkg::result_t          result,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [35:0]          cfg_data
);

    localparam int AW  = bpa_pkg::ADDR_W;
    localparam int LW  = bpa_pkg::LINK_W;
    localparam int MW  = bpa_pkg::MARK_W;
    localparam int OW  = bpa_pkg::ORD_W;
    localparam int TW  = bpa_pkg::TAG_W;
    localparam int NL  = bpa_pkg::LISTS;
    localparam int NS  = bpa_pkg::RESERVE_SLOTS;
    localparam int SW  = bpa_pkg::SLOT_IW;
    localparam int UW  = bpa_pkg::USED_W;
    localparam int PN  = bpa_pkg::PAGE_NW;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_MARK     = 5'd1;
    localparam logic [4:0] S_AP1      = 5'd2;
    localparam logic [4:0] S_AP2      = 5'd3;
    localparam logic [4:0] S_UN1      = 5'd4;
    localparam logic [4:0] S_UN2      = 5'd5;
    localparam logic [4:0] S_UN3      = 5'd6;
    localparam logic [4:0] S_CK0      = 5'd7;
    localparam logic [4:0] S_CK1      = 5'd8;
    localparam logic [4:0] S_CK2      = 5'd9;
    localparam logic [4:0] S_B_INIT   = 5'd10;
    localparam logic [4:0] S_B_TOP    = 5'd11;
    localparam logic [4:0] S_B_AFTER  = 5'd12;
    localparam logic [4:0] S_B_ORD    = 5'd13;
    localparam logic [4:0] S_B_CARVE  = 5'd14;
    localparam logic [4:0] S_B_TAIL   = 5'd15;
    localparam logic [4:0] S_B_NEXT   = 5'd16;
    localparam logic [4:0] S_AL0      = 5'd17;
    localparam logic [4:0] S_AL_SPLIT = 5'd18;
    localparam logic [4:0] S_AL_SPT   = 5'd19;
    localparam logic [4:0] S_AL_FIN   = 5'd20;
    localparam logic [4:0] S_AL_DONE  = 5'd21;
    localparam logic [4:0] S_FR0      = 5'd22;
    localparam logic [4:0] S_FR1      = 5'd23;
    localparam logic [4:0] S_FR_LOOP  = 5'd24;
    localparam logic [4:0] S_FR_BUD   = 5'd25;
    localparam logic [4:0] S_FR_MERGE = 5'd26;
    localparam logic [4:0] S_FR_APP   = 5'd27;
    localparam logic [4:0] S_FR_DONE  = 5'd28;

    // memories
    bpa_pkg::page_ent_t page_mem [bpa_pkg::PAGES];
    bpa_pkg::link_ent_t link_mem [bpa_pkg::PAGES];

    logic               pg_we, pg_re;
    logic [AW-1:0]      pg_addr;
    bpa_pkg::page_ent_t pg_wdata, pg_rd;

    logic               lk_we_n, lk_we_p, lk_re;
    logic [AW-1:0]      lk_addr;
    bpa_pkg::link_ent_t lk_wdata, lk_rd;

    always_ff @(posedge clk)
    begin
        if (pg_we)
        begin
            page_mem[pg_addr] <= pg_wdata;
        end
        if (pg_re)
        begin
            pg_rd <= page_mem[pg_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lk_we_n)
        begin
            link_mem[lk_addr].nxt <= lk_wdata.nxt;
        end
        if (lk_we_p)
        begin
            link_mem[lk_addr].prv <= lk_wdata.prv;
        end
        if (lk_re)
        begin
            lk_rd <= link_mem[lk_addr];
        end
    end

    // registers
    logic [4:0]     state_reg, state_next;
    logic [4:0]     mark_ret_reg, mark_ret_next;
    logic [4:0]     app_ret_reg, app_ret_next;
    logic [4:0]     unl_ret_reg, unl_ret_next;
    logic [MW-1:0]  mark_ptr_reg, mark_ptr_next;
    logic [MW-1:0]  mark_end_reg, mark_end_next;
    logic [TW-1:0]  mark_tag_reg, mark_tag_next;
    logic           mark_use_reg, mark_use_next;
    logic [OW-1:0]  app_ord_reg, app_ord_next;
    logic [AW-1:0]  app_p_reg, app_p_next;
    logic [LW-1:0]  app_last_reg, app_last_next;
    logic [OW-1:0]  unl_ord_reg, unl_ord_next;
    logic [AW-1:0]  unl_p_reg, unl_p_next;
    logic [LW-1:0]  unl_nx_reg, unl_nx_next;
    logic [LW-1:0]  unl_pr_reg, unl_pr_next;
    bpa_pkg::cmd_t  cmd_reg, cmd_next;
    logic [LW-1:0]  idx_reg, idx_next;
    logic [OW-1:0]  ord_reg, ord_next;
    logic [AW-1:0]  p_reg, p_next;
    logic [LW-1:0]  b_reg, b_next;
    logic           single_reg, single_next;
    logic           hit_reg, hit_next;
    logic [UW-1:0]  slot_reg, slot_next;
    logic [PN:0]    a0_reg, a0_next;
    logic [PN:0]    a1_reg, a1_next;
    logic [MW-1:0]  chk_n_reg, chk_n_next;
    logic [LW-1:0]  list_first_reg [NL];
    logic [LW-1:0]  list_first_next [NL];
    logic [LW-1:0]  list_last_reg [NL];
    logic [LW-1:0]  list_last_next [NL];
    logic [PN-1:0]  res_first_reg [NS];
    logic [PN-1:0]  res_first_next [NS];
    logic [PN:0]    res_end_reg [NS];
    logic [PN:0]    res_end_next [NS];
    logic [UW-1:0]  res_used_reg, res_used_next;
    logic [bpa_pkg::PC_W-1:0] page_count_reg;
    logic [PN-1:0]  base_page_reg;
    logic           done_reg, done_next;
    bpa_pkg::result_t result_reg, result_next;

    logic [LW-1:0]  cnt;
    assign cnt = (page_count_reg > bpa_pkg::PC_W'(bpa_pkg::PAGES))
                 ? LW'(bpa_pkg::PAGES) : LW'(page_count_reg);

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_count_reg <= bpa_pkg::PC_W'(1024);
            base_page_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bpa_pkg::CFG_PAGE_COUNT: page_count_reg <= cfg_data[bpa_pkg::PC_W-1:0];
                bpa_pkg::CFG_BASE_PAGE:  base_page_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic              found;
    logic [OW-1:0]     fk;
    logic [LW-1:0]     last_w;
    logic [LW-1:0]     b_w;
    logic [AW-1:0]     pm_w;
    logic [OW-1:0]     o_w;
    logic [MW-1:0]     n_w;
    logic [SW-1:0]     si;

    always_comb
    begin
        state_next     = state_reg;
        mark_ret_next  = mark_ret_reg;
        app_ret_next   = app_ret_reg;
        unl_ret_next   = unl_ret_reg;
        mark_ptr_next  = mark_ptr_reg;
        mark_end_next  = mark_end_reg;
        mark_tag_next  = mark_tag_reg;
        mark_use_next  = mark_use_reg;
        app_ord_next   = app_ord_reg;
        app_p_next     = app_p_reg;
        app_last_next  = app_last_reg;
        unl_ord_next   = unl_ord_reg;
        unl_p_next     = unl_p_reg;
        unl_nx_next    = unl_nx_reg;
        unl_pr_next    = unl_pr_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        ord_next       = ord_reg;
        p_next         = p_reg;
        b_next         = b_reg;
        single_next    = single_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        a0_next        = a0_reg;
        a1_next        = a1_reg;
        chk_n_next     = chk_n_reg;
        list_first_next = list_first_reg;
        list_last_next  = list_last_reg;
        res_first_next  = res_first_reg;
        res_end_next    = res_end_reg;
        res_used_next   = res_used_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        pg_we    = 1'b0;
        pg_re    = 1'b0;
        pg_addr  = '0;
        pg_wdata = '0;
        lk_we_n  = 1'b0;
        lk_we_p  = 1'b0;
        lk_re    = 1'b0;
        lk_addr  = '0;
        lk_wdata = '0;
        found    = 1'b0;
        fk       = '0;
        last_w   = '0;
        b_w      = '0;
        pm_w     = '0;
        o_w      = '0;
        n_w      = '0;
        si       = slot_reg[SW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    case (cmd.opcode)
                        bpa_pkg::OP_RESERVE:
                        begin
                            done_next = 1'b1;
                            result_next = '0;
                            if (cmd.range_pages == '0 || res_used_reg >= UW'(NS))
                            begin
                                result_next.status = bpa_pkg::ST_REJECT;
                            end
                            else
                            begin
                                res_first_next[res_used_reg[SW-1:0]] = cmd.range_start;
                                res_end_next[res_used_reg[SW-1:0]] =
                                    {1'b0, cmd.range_start} + {1'b0, cmd.range_pages};
                                res_used_next = res_used_reg + UW'(1);
                                result_next.status = bpa_pkg::ST_DONE;
                            end
                        end
                        bpa_pkg::OP_BUILD:
                        begin
                            for (int k = 0; k < NL; k++)
                            begin
                                list_first_next[k] = bpa_pkg::NIL;
                                list_last_next[k]  = bpa_pkg::NIL;
                            end
                            mark_ptr_next = '0;
                            mark_end_next = MW'(bpa_pkg::PAGES);
                            mark_tag_next = bpa_pkg::TAG_RESERVED;
                            mark_use_next = 1'b1;
                            mark_ret_next = S_B_INIT;
                            state_next    = S_MARK;
                        end
                        bpa_pkg::OP_ALLOCATE: state_next = S_AL0;
                        default:              state_next = S_FR0;
                    endcase
                end
            end

            S_MARK:
            begin
                if (mark_ptr_reg < mark_end_reg && mark_ptr_reg < MW'(bpa_pkg::PAGES))
                begin
                    pg_we         = 1'b1;
                    pg_addr       = mark_ptr_reg[AW-1:0];
                    pg_wdata.tag  = mark_tag_reg;
                    pg_wdata.used = mark_use_reg;
                    mark_ptr_next = mark_ptr_reg + MW'(1);
                end
                else
                begin
                    state_next = mark_ret_reg;
                end
            end

            S_AP1:
            begin
                last_w         = list_last_reg[app_ord_reg];
                lk_we_n        = 1'b1;
                lk_we_p        = 1'b1;
                lk_addr        = app_p_reg;
                lk_wdata.nxt   = bpa_pkg::NIL;
                lk_wdata.prv   = last_w;
                app_last_next  = last_w;
                list_last_next[app_ord_reg] = {1'b0, app_p_reg};
                if (last_w < bpa_pkg::NIL)
                begin
                    state_next = S_AP2;
                end
                else
                begin
                    list_first_next[app_ord_reg] = {1'b0, app_p_reg};
                    state_next = app_ret_reg;
                end
            end

            S_AP2:
            begin
                lk_we_n      = 1'b1;
                lk_addr      = app_last_reg[AW-1:0];
                lk_wdata.nxt = {1'b0, app_p_reg};
                state_next   = app_ret_reg;
            end

            S_UN1:
            begin
                lk_re      = 1'b1;
                lk_addr    = unl_p_reg;
                state_next = S_UN2;
            end

            S_UN2:
            begin
                unl_pr_next = lk_rd.prv;
                unl_nx_next = lk_rd.nxt;
                if (lk_rd.prv < bpa_pkg::NIL)
                begin
                    lk_we_n      = 1'b1;
                    lk_addr      = lk_rd.prv[AW-1:0];
                    lk_wdata.nxt = lk_rd.nxt;
                end
                else
                begin
                    list_first_next[unl_ord_reg] = lk_rd.nxt;
                end
                state_next = S_UN3;
            end

            S_UN3:
            begin
                if (unl_nx_reg < bpa_pkg::NIL)
                begin
                    lk_we_p      = 1'b1;
                    lk_addr      = unl_nx_reg[AW-1:0];
                    lk_wdata.prv = unl_pr_reg;
                end
                else
                begin
                    list_last_next[unl_ord_reg] = unl_pr_reg;
                end
                state_next = unl_ret_reg;
            end

            S_CK0:
            begin
                a0_next    = {1'b0, base_page_reg} + (PN+1)'(idx_reg);
                state_next = S_CK1;
            end

            S_CK1:
            begin
                a1_next    = a0_reg + (PN+1)'(chk_n_reg);
                slot_next  = '0;
                state_next = S_CK2;
            end

            S_CK2:
            begin
                if (slot_reg >= res_used_reg)
                begin
                    hit_next   = 1'b0;
                    state_next = S_B_AFTER;
                end
                else if (!(a1_reg <= {1'b0, res_first_reg[si]} || res_end_reg[si] <= a0_reg))
                begin
                    hit_next   = 1'b1;
                    state_next = S_B_AFTER;
                end
                else
                begin
                    slot_next = slot_reg + UW'(1);
                end
            end

            S_B_INIT:
            begin
                idx_next   = '0;
                state_next = S_B_TOP;
            end

            S_B_TOP:
            begin
                if (idx_reg >= cnt)
                begin
                    done_next   = 1'b1;
                    result_next = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    single_next = 1'b1;
                    chk_n_next  = MW'(1);
                    state_next  = S_CK0;
                end
            end

            S_B_AFTER:
            begin
                if (single_reg)
                begin
                    if (hit_reg)
                    begin
                        idx_next   = idx_reg + LW'(1);
                        state_next = S_B_TOP;
                    end
                    else
                    begin
                        ord_next   = OW'(bpa_pkg::TOP_ORDER);
                        state_next = S_B_ORD;
                    end
                end
                else if (!hit_reg)
                begin
                    state_next = S_B_CARVE;
                end
                else
                begin
                    ord_next   = ord_reg - OW'(1);
                    state_next = S_B_ORD;
                end
            end

            S_B_ORD:
            begin
                n_w = bpa_pkg::ord_size(ord_reg);
                if (ord_reg == '0)
                begin
                    state_next = S_B_CARVE;
                end
                else if ((MW'(idx_reg) & (n_w - MW'(1))) == '0
                         && MW'(idx_reg) + n_w <= MW'(cnt))
                begin
                    single_next = 1'b0;
                    chk_n_next  = n_w;
                    state_next  = S_CK0;
                end
                else
                begin
                    ord_next = ord_reg - OW'(1);
                end
            end

            S_B_CARVE:
            begin
                pg_we         = 1'b1;
                pg_addr       = idx_reg[AW-1:0];
                pg_wdata.tag  = TW'(ord_reg);
                pg_wdata.used = 1'b0;
                app_ord_next  = ord_reg;
                app_p_next    = idx_reg[AW-1:0];
                app_ret_next  = S_B_TAIL;
                state_next    = S_AP1;
            end

            S_B_TAIL:
            begin
                mark_ptr_next = MW'(idx_reg) + MW'(1);
                mark_end_next = MW'(idx_reg) + bpa_pkg::ord_size(ord_reg);
                mark_tag_next = bpa_pkg::TAG_TAIL;
                mark_use_next = 1'b0;
                mark_ret_next = S_B_NEXT;
                state_next    = S_MARK;
            end

            S_B_NEXT:
            begin
                idx_next   = LW'(MW'(idx_reg) + bpa_pkg::ord_size(ord_reg));
                state_next = S_B_TOP;
            end

            S_AL0:
            begin
                for (int k = NL - 1; k >= 0; k--)
                begin
                    if (OW'(k) >= cmd_reg.block_order && list_first_reg[k] < bpa_pkg::NIL)
                    begin
                        found = 1'b1;
                        fk    = OW'(k);
                    end
                end
                if (cmd_reg.block_order > OW'(bpa_pkg::TOP_ORDER))
                begin
                    done_next          = 1'b1;
                    result_next        = '0;
                    result_next.status = bpa_pkg::ST_REJECT;
                    state_next         = S_IDLE;
                end
                else if (!found)
                begin
                    done_next          = 1'b1;
                    result_next        = '0;
                    result_next.status = bpa_pkg::ST_EMPTY;
                    state_next         = S_IDLE;
                end
                else
                begin
                    ord_next     = fk;
                    p_next       = list_first_reg[fk][AW-1:0];
                    unl_ord_next = fk;
                    unl_p_next   = list_first_reg[fk][AW-1:0];
                    unl_ret_next = S_AL_SPLIT;
                    state_next   = S_UN1;
                end
            end

            S_AL_SPLIT:
            begin
                if (ord_reg > cmd_reg.block_order)
                begin
                    o_w      = ord_reg - OW'(1);
                    b_w      = LW'(MW'(p_reg) + bpa_pkg::ord_size(o_w));
                    ord_next = o_w;
                    b_next   = b_w;
                    if (b_w < bpa_pkg::NIL)
                    begin
                        pg_we         = 1'b1;
                        pg_addr       = b_w[AW-1:0];
                        pg_wdata.tag  = TW'(o_w);
                        pg_wdata.used = 1'b0;
                        app_ord_next  = o_w;
                        app_p_next    = b_w[AW-1:0];
                        app_ret_next  = S_AL_SPT;
                        state_next    = S_AP1;
                    end
                    else
                    begin
                        state_next = S_AL_SPT;
                    end
                end
                else
                begin
                    state_next = S_AL_FIN;
                end
            end

            S_AL_SPT:
            begin
                mark_ptr_next = MW'(b_reg) + MW'(1);
                mark_end_next = MW'(b_reg) + bpa_pkg::ord_size(ord_reg);
                mark_tag_next = bpa_pkg::TAG_TAIL;
                mark_use_next = 1'b0;
                mark_ret_next = S_AL_SPLIT;
                state_next    = S_MARK;
            end

            S_AL_FIN:
            begin
                pg_we         = 1'b1;
                pg_addr       = p_reg;
                pg_wdata.tag  = TW'(cmd_reg.block_order);
                pg_wdata.used = 1'b1;
                mark_ptr_next = MW'(p_reg) + MW'(1);
                mark_end_next = MW'(p_reg) + bpa_pkg::ord_size(cmd_reg.block_order);
                mark_tag_next = bpa_pkg::TAG_RESERVED;
                mark_use_next = 1'b1;
                mark_ret_next = S_AL_DONE;
                state_next    = S_MARK;
            end

            S_AL_DONE:
            begin
                done_next                = 1'b1;
                result_next.status       = bpa_pkg::ST_DONE;
                result_next.result_page  = p_reg;
                result_next.result_order = cmd_reg.block_order;
                state_next               = S_IDLE;
            end

            S_FR0:
            begin
                if ({1'b0, cmd_reg.page_index} >= cnt)
                begin
                    done_next          = 1'b1;
                    result_next        = '0;
                    result_next.status = bpa_pkg::ST_REJECT;
                    state_next         = S_IDLE;
                end
                else
                begin
                    pg_re      = 1'b1;
                    pg_addr    = cmd_reg.page_index;
                    p_next     = cmd_reg.page_index;
                    state_next = S_FR1;
                end
            end

            S_FR1:
            begin
                if (!pg_rd.used || pg_rd.tag > TW'(bpa_pkg::TOP_ORDER))
                begin
                    done_next          = 1'b1;
                    result_next        = '0;
                    result_next.status = bpa_pkg::ST_REJECT;
                    state_next         = S_IDLE;
                end
                else
                begin
                    ord_next      = pg_rd.tag[OW-1:0];
                    pg_we         = 1'b1;
                    pg_addr       = p_reg;
                    pg_wdata.tag  = pg_rd.tag;
                    pg_wdata.used = 1'b0;
                    mark_ptr_next = MW'(p_reg) + MW'(1);
                    mark_end_next = MW'(p_reg) + bpa_pkg::ord_size(pg_rd.tag[OW-1:0]);
                    mark_tag_next = bpa_pkg::TAG_TAIL;
                    mark_use_next = 1'b0;
                    mark_ret_next = S_FR_LOOP;
                    state_next    = S_MARK;
                end
            end

            S_FR_LOOP:
            begin
                b_w = LW'(MW'(p_reg) ^ bpa_pkg::ord_size(ord_reg));
                if (ord_reg < OW'(bpa_pkg::TOP_ORDER) && b_w < cnt)
                begin
                    b_next     = b_w;
                    pg_re      = 1'b1;
                    pg_addr    = b_w[AW-1:0];
                    state_next = S_FR_BUD;
                end
                else
                begin
                    state_next = S_FR_APP;
                end
            end

            S_FR_BUD:
            begin
                if (pg_rd.used || pg_rd.tag != TW'(ord_reg))
                begin
                    state_next = S_FR_APP;
                end
                else
                begin
                    unl_ord_next = ord_reg;
                    unl_p_next   = b_reg[AW-1:0];
                    unl_ret_next = S_FR_MERGE;
                    state_next   = S_UN1;
                end
            end

            S_FR_MERGE:
            begin
                pm_w          = (b_reg[AW-1:0] < p_reg) ? b_reg[AW-1:0] : p_reg;
                o_w           = ord_reg + OW'(1);
                p_next        = pm_w;
                ord_next      = o_w;
                pg_we         = 1'b1;
                pg_addr       = pm_w;
                pg_wdata.tag  = TW'(o_w);
                pg_wdata.used = 1'b0;
                mark_ptr_next = MW'(pm_w) + MW'(1);
                mark_end_next = MW'(pm_w) + bpa_pkg::ord_size(o_w);
                mark_tag_next = bpa_pkg::TAG_TAIL;
                mark_use_next = 1'b0;
                mark_ret_next = S_FR_LOOP;
                state_next    = S_MARK;
            end

            S_FR_APP:
            begin
                app_ord_next = ord_reg;
                app_p_next   = p_reg;
                app_ret_next = S_FR_DONE;
                state_next   = S_AP1;
            end

            S_FR_DONE:
            begin
                done_next                = 1'b1;
                result_next.status       = bpa_pkg::ST_DONE;
                result_next.result_page  = p_reg;
                result_next.result_order = ord_reg;
                state_next               = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // page memory clearing pass
            state_reg     <= S_MARK;
            mark_ret_reg  <= S_IDLE;
            mark_ptr_reg  <= '0;
            mark_end_reg  <= MW'(bpa_pkg::PAGES);
            mark_tag_reg  <= bpa_pkg::TAG_RESERVED;
            mark_use_reg  <= 1'b1;
            app_ret_reg   <= S_IDLE;
            unl_ret_reg   <= S_IDLE;
            single_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            slot_reg      <= '0;
            res_used_reg  <= '0;
            done_reg      <= 1'b0;
            for (int k = 0; k < NL; k++)
            begin
                list_first_reg[k] <= bpa_pkg::NIL;
                list_last_reg[k]  <= bpa_pkg::NIL;
            end
        end
        else
        begin
            state_reg      <= state_next;
            mark_ret_reg   <= mark_ret_next;
            mark_ptr_reg   <= mark_ptr_next;
            mark_end_reg   <= mark_end_next;
            mark_tag_reg   <= mark_tag_next;
            mark_use_reg   <= mark_use_next;
            app_ret_reg    <= app_ret_next;
            unl_ret_reg    <= unl_ret_next;
            single_reg     <= single_next;
            hit_reg        <= hit_next;
            slot_reg       <= slot_next;
            res_used_reg   <= res_used_next;
            done_reg       <= done_next;
            list_first_reg <= list_first_next;
            list_last_reg  <= list_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        app_ord_reg   <= app_ord_next;
        app_p_reg     <= app_p_next;
        app_last_reg  <= app_last_next;
        unl_ord_reg   <= unl_ord_next;
        unl_p_reg     <= unl_p_next;
        unl_nx_reg    <= unl_nx_next;
        unl_pr_reg    <= unl_pr_next;
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        ord_reg       <= ord_next;
        p_reg         <= p_next;
        b_reg         <= b_next;
        a0_reg        <= a0_next;
        a1_reg        <= a1_next;
        chk_n_reg     <= chk_n_next;
        res_first_reg <= res_first_next;
        res_end_reg   <= res_end_next;
        result_reg    <= result_next;
    end

endmodule

`default_nettype wire

### bench/buddy_page_allocator_check.sv
`timescale 1ns / 1ps

module buddy_page_allocator_check
    import bpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  cmd_t        cmd,
    input  logic        done,
    input  result_t     result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [35:0] cfg_data,
    output int          errors
);

    logic [10:0] pg_count;
    logic [35:0] base_pg;
    logic [35:0] rsv_first [RESERVE_SLOTS];
    logic [35:0] rsv_len [RESERVE_SLOTS];
    int          rsv_used;
    logic [4:0]  tag [PAGES];
    bit          in_use [PAGES];
    int          nxt [PAGES];
    int          prv [PAGES];
    int          head [LISTS];
    int          tail [LISTS];
    result_t     expected_results [$];

    function automatic int active_page_count();
        return (pg_count > PAGES) ? PAGES : int'(pg_count);
    endfunction

    function automatic void clear_lists();
        for (int k = 0; k < LISTS; k++)
        begin
            head[k] = PAGES;
            tail[k] = PAGES;
        end
    endfunction

    function automatic void mark_pages(int first, int count, logic [4:0] tg, bit u);
        for (int j = 0; j < count; j++)
        begin
            if (first + j >= PAGES)
                break;
            tag[first + j] = tg;
            in_use[first + j] = u;
        end
    endfunction

    function automatic void list_append(int o, int p);
        int last;
        if (o > TOP_ORDER || p >= PAGES)
            return;
        last = tail[o];
        nxt[p] = PAGES;
        prv[p] = last;
        if (last < PAGES)
            nxt[last] = p;
        else
            head[o] = p;
        tail[o] = p;
    endfunction

    function automatic void list_remove(int o, int p);
        int pr;
        int nx;
        if (o > TOP_ORDER || p >= PAGES)
            return;
        pr = prv[p];
        nx = nxt[p];
        if (pr < PAGES)
            nxt[pr] = nx;
        else
            head[o] = nx;
        if (nx < PAGES)
            prv[nx] = pr;
        else
            tail[o] = pr;
    endfunction

    function automatic bit hits_reserved(int idx, int count);
        logic [37:0] a0;
        logic [37:0] a1;
        logic [37:0] r0;
        logic [37:0] r1;
        a0 = 38'(base_pg) + 38'(idx);
        a1 = a0 + 38'(count);
        for (int i = 0; i < rsv_used && i < RESERVE_SLOTS; i++)
        begin
            r0 = 38'(rsv_first[i]);
            r1 = r0 + 38'(rsv_len[i]);
            if (!(a1 <= r0 || r1 <= a0))
                return 1;
        end
        return 0;
    endfunction

    function automatic void build_lists();
        int cnt;
        int idx;
        int o;
        cnt = active_page_count();
        idx = 0;
        clear_lists();
        mark_pages(0, PAGES, TAG_RESERVED, 1);
        while (idx < cnt)
        begin
            o = TOP_ORDER;
            if (hits_reserved(idx, 1))
            begin
                idx++;
                continue;
            end
            while (o > 0)
            begin
                if ((idx & ((1 << o) - 1)) == 0 && idx + (1 << o) <= cnt
                    && !hits_reserved(idx, 1 << o))
                    break;
                o--;
            end
            tag[idx] = 5'(o);
            in_use[idx] = 0;
            list_append(o, idx);
            mark_pages(idx + 1, (1 << o) - 1, TAG_TAIL, 0);
            idx += 1 << o;
        end
    endfunction

    function automatic result_t predict_result(cmd_t c);
        result_t r;
        int cur;
        int want;
        int p;
        int b;
        int o;
        int cnt;
        r = '0;
        r.status = ST_DONE;
        want = int'(c.block_order);
        case (c.opcode)
            OP_RESERVE:
            begin
                if (c.range_pages == 0 || rsv_used >= RESERVE_SLOTS)
                    r.status = ST_REJECT;
                else
                begin
                    rsv_first[rsv_used] = c.range_start;
                    rsv_len[rsv_used] = c.range_pages;
                    rsv_used++;
                end
            end
            OP_BUILD:
                build_lists();
            OP_ALLOCATE:
            begin
                if (want > TOP_ORDER)
                    r.status = ST_REJECT;
                else
                begin
                    cur = want;
                    while (cur <= TOP_ORDER && head[cur] >= PAGES)
                        cur++;
                    if (cur > TOP_ORDER)
                        r.status = ST_EMPTY;
                    else
                    begin
                        p = head[cur];
                        list_remove(cur, p);
                        while (cur > want)
                        begin
                            cur--;
                            b = p + (1 << cur);
                            if (b < PAGES)
                            begin
                                tag[b] = 5'(cur);
                                in_use[b] = 0;
                                list_append(cur, b);
                            end
                            mark_pages(b + 1, (1 << cur) - 1, TAG_TAIL, 0);
                        end
                        tag[p] = 5'(want);
                        in_use[p] = 1;
                        mark_pages(p + 1, (1 << want) - 1, TAG_RESERVED, 1);
                        r.result_page = 10'(p);
                        r.result_order = 4'(want);
                    end
                end
            end
            default:
            begin
                cnt = active_page_count();
                p = int'(c.page_index);
                if (p >= cnt || !in_use[p] || tag[p] > TOP_ORDER)
                    r.status = ST_REJECT;
                else
                begin
                    o = int'(tag[p]);
                    in_use[p] = 0;
                    mark_pages(p + 1, (1 << o) - 1, TAG_TAIL, 0);
                    while (o < TOP_ORDER)
                    begin
                        b = p ^ (1 << o);
                        if (b >= cnt)
                            break;
                        if (in_use[b] || tag[b] != 5'(o))
                            break;
                        list_remove(o, b);
                        if (b < p)
                            p = b;
                        o++;
                        tag[p] = 5'(o);
                        mark_pages(p + 1, (1 << o) - 1, TAG_TAIL, 0);
                    end
                    list_append(o, p);
                    r.result_page = 10'(p);
                    r.result_order = 4'(o);
                end
            end
        endcase
        return r;
    endfunction

    initial
    begin
        errors = 0;
        pg_count = 11'd1024;
        base_pg = '0;
        rsv_used = 0;
        for (int i = 0; i < RESERVE_SLOTS; i++)
        begin
            rsv_first[i] = '0;
            rsv_len[i] = '0;
        end
        for (int i = 0; i < PAGES; i++)
        begin
            tag[i] = TAG_RESERVED;
            in_use[i] = 1;
            nxt[i] = 0;
            prv[i] = 0;
        end
        clear_lists();
    end

    always @(posedge clk)
    begin
        result_t want_r;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_PAGE_COUNT)
                    pg_count = cfg_data[10:0];
                else
                    base_pg = cfg_data;
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %p", result);
                end
                else
                begin
                    want_r = expected_results.pop_front();
                    if (result.status !== want_r.status
                        || result.result_page !== want_r.result_page
                        || result.result_order !== want_r.result_order)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p, got %p", want_r, result);
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(predict_result(cmd));
        end
    end

endmodule

### bench/buddy_page_allocator_top_test.sv
`timescale 1ns / 1ps

module buddy_page_allocator_top_test;
    import bpa_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    cmd_t        cmd = '0;
    logic        done;
    result_t     result;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [35:0] cfg_data = '0;
    int          errors;

    int          outstanding = 0;
    logic [1:0]  sent_ops [$];
    int          live_heads [$];
    bit          gaps_on = 1;
    logic [35:0] cur_base = '0;

    buddy_page_allocator_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    buddy_page_allocator_check checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .errors(errors)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        logic [1:0] op;
        if (done && sent_ops.size() > 0)
        begin
            op = sent_ops.pop_front();
            outstanding--;
            if (op == OP_ALLOCATE && result.status == ST_DONE)
                live_heads.push_back(int'(result.result_page));
        end
    end

    task automatic send_item(cmd_t c);
        bit ok;
        start <= 1;
        cmd <= c;
        forever
        begin
            @(negedge clk);
            ok = !busy;
            @(posedge clk);
            if (ok)
                break;
        end
        outstanding++;
        sent_ops.push_back(c.opcode);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic cmd_t noise_cmd(logic [1:0] op);
        cmd_t c;
        c.opcode = op;
        c.block_order = 4'($urandom);
        c.page_index = 10'($urandom);
        c.range_start = {4'($urandom), 32'($urandom)};
        c.range_pages = {4'($urandom), 32'($urandom)};
        return c;
    endfunction

    task automatic send_op(logic [1:0] op, int ord, int pg, logic [35:0] rs, logic [35:0] rp);
        cmd_t c;
        c = noise_cmd(op);
        c.block_order = 4'(ord);
        c.page_index = 10'(pg);
        if (op == OP_RESERVE)
        begin
            c.range_start = rs;
            c.range_pages = rp;
        end
        if (op == OP_BUILD)
            live_heads.delete();
        send_item(c);
    endtask

    task automatic wait_idle();
        start <= 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [35:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic free_some();
        int k;
        if (live_heads.size() > 0 && $urandom_range(0, 9) != 0)
        begin
            k = $urandom_range(0, live_heads.size() - 1);
            send_op(OP_FREE, 0, live_heads[k], 0, 0);
            live_heads.delete(k);
        end
        else
            send_op(OP_FREE, 0, $urandom_range(0, 1023), 0, 0);
    endtask

    task automatic run_phase(int n);
        int r;
        int ord;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 48)
            begin
                ord = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, 3);
                send_op(OP_ALLOCATE, ord, 0, 0, 0);
            end
            else if (r < 97)
                free_some();
            else if (r < 98)
                send_op(OP_BUILD, 0, 0, 0, 0);
            else
                send_op(OP_RESERVE, 0, 0, cur_base + 36'($urandom_range(0, 1100)),
                        36'($urandom_range(0, 8)));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // before any build: empty lists, rejected orders and frees
        send_op(OP_ALLOCATE, 0, 0, 0, 0);
        send_op(OP_ALLOCATE, 11, 0, 0, 0);
        send_op(OP_ALLOCATE, 15, 0, 0, 0);
        send_op(OP_FREE, 0, 0, 0, 0);
        send_op(OP_FREE, 0, 1023, 0, 0);
        send_op(OP_RESERVE, 0, 0, 36'd5, 36'd0);
        send_op(OP_RESERVE, 0, 0, 36'd100, 36'd3);
        send_op(OP_RESERVE, 0, 0, '1, '1);
        send_op(OP_BUILD, 0, 0, 0, 0);
        send_op(OP_ALLOCATE, 10, 0, 0, 0);
        send_op(OP_ALLOCATE, 0, 0, 0, 0);
        send_op(OP_ALLOCATE, 0, 0, 0, 0);
        send_op(OP_ALLOCATE, 6, 0, 0, 0);
        wait_idle();
        while (live_heads.size() > 0)
            free_some();
        send_op(OP_FREE, 0, 64, 0, 0);

        for (int ph = 0; ph < 12; ph++)
        begin
            wait_idle();
            case (ph)
                0: write_reg(CFG_PAGE_COUNT, 36'd1);
                1: write_reg(CFG_PAGE_COUNT, 36'd2047);
                2: write_reg(CFG_PAGE_COUNT, 36'd0);
                3: write_reg(CFG_PAGE_COUNT, 36'd1024);
                default: write_reg(CFG_PAGE_COUNT, 36'($urandom_range(1, 1100)));
            endcase
            case (ph)
                1: cur_base = '1;
                2: cur_base = '0;
                5: cur_base = 36'hFFFFFFC00;
                default: cur_base = {4'($urandom), 32'($urandom)};
            endcase
            write_reg(CFG_BASE_PAGE, cur_base);
            if (ph < 4 && $urandom_range(0, 1) == 0)
                send_op(OP_RESERVE, 0, 0, cur_base + 36'($urandom_range(0, 1023)),
                        36'($urandom_range(1, 20)));
            send_op(OP_BUILD, 0, 0, 0, 0);
            if (ph == 6)
            begin
                send_op(OP_RESERVE, 0, 0, 36'd0, 36'd1);
                send_op(OP_RESERVE, 0, 0, 36'd0, 36'd1);
                send_op(OP_RESERVE, 0, 0, 36'd0, 36'd1);
                send_op(OP_RESERVE, 0, 0, 36'd0, 36'd1);
                send_op(OP_RESERVE, 0, 0, 36'd0, 36'd1);
            end
            if (ph == 11)
                gaps_on = 0;
            run_phase(150);
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #1000000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
